/* rtl/fscm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fscm_pkg
// Types and constants for the fan calibration and target mapping block.
// ----------------------------------------------------------------------------
package fscm_pkg;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_TARGET = 2'd2;

  localparam logic [7:0]  FULL_PWM     = 8'h7f;
  localparam logic [15:0] STEP_RPM     = 16'd50;
  localparam logic [2:0]  STABLE_LIMIT = 3'd5;

  localparam logic PWM_REG_FORCE = 1'b0;
  localparam logic PWM_REG_START = 1'b1;

  // shared divider: 21-bit dividend (14-bit rpm times 127), 16-bit divisor
  localparam int DIV_W     = 21;
  localparam int DIV_CNT_W = 5;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] tach_rpm;
    logic [15:0] target_word;
  } item_t;

  typedef struct packed {
    logic        pwm_write;
    logic        pwm_target_reg;
    logic [7:0]  pwm_value;
    logic [15:0] max_speed_word;
    logic [15:0] initial_speed_word;
    logic [15:0] min_speed_word;
    logic        targets_enabled;
    logic        busy_calibrating;
    logic        calibration_done;
  } result_t;

endpackage
`default_nettype wire

/* rtl/fan_speed_calibrate_and_map.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fan_speed_calibrate_and_map
// Fan calibration run and fpe2 target to PWM slope mapping for one fan.
// ----------------------------------------------------------------------------
// Usage:
//   item channel   : opcode, tach_rpm, target_word; one transaction per item.
//   result channel : one result transaction per item, held in an output
//                    register until taken.
//   cfg channel    : saved PWM control byte, always ready.
// Timing: one item is in work at a time. Items that need no division go
//   straight from acceptance to the FINISH state, which loads their result;
//   the next item can be taken once that result is loaded. A calibration
//   start, the sample that ends a run and a mapped target use the shared
//   restoring divider, one quotient bit per cycle over 21 bits, then pass
//   through the APPLY and FINISH states.
//   item_ready returns at the same edge that loads the result.
// If the receiver stalls, the finished result waits in the output register
//   and the next item may already be taken; its own result then waits until
//   the register frees up.
// Reset clears all calibration state, the saved setting and the output
//   valid flag; the block is already ready when reset drops.
// ----------------------------------------------------------------------------
module fan_speed_calibrate_and_map (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire fscm_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output fscm_pkg::result_t     result,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [7:0]       cfg_data
);
  import fscm_pkg::*;

  typedef enum logic [1:0] {IDLE, DIVIDE, APPLY, FINISH} state_t;
  typedef enum logic [1:0] {JOB_INIT, JOB_MAX, JOB_SLOPE} job_t;

  state_t state;
  job_t   job;

  logic [7:0]  saved_pwm;
  logic [15:0] first_round;
  logic [15:0] last_rise;
  logic [15:0] top_speed;
  logic [2:0]  stable_count;
  logic        calibrating;
  logic        accept_targets;

  logic        pwm_write;
  logic        pwm_reg;
  logic [7:0]  pwm_value;
  logic        done;

  logic [15:0]          div_rem;
  logic [DIV_W-1:0]     div_quo;
  logic [15:0]          div_dsr;
  logic [DIV_CNT_W-1:0] div_cnt;

  // one restoring division step
  logic [16:0] rem_shift;
  logic [16:0] rem_diff;
  logic        fits;
  logic [15:0] div_rem_next;
  logic [DIV_W-1:0] div_quo_next;

  assign rem_shift    = {div_rem, div_quo[DIV_W-1]};
  assign rem_diff     = rem_shift - {1'b0, div_dsr};
  assign fits         = rem_shift >= {1'b0, div_dsr};
  assign div_rem_next = fits ? rem_diff[15:0] : rem_shift[15:0];
  assign div_quo_next = {div_quo[DIV_W-2:0], fits};

  // item decode
  logic [16:0] rise_limit;
  logic        stable;
  logic [2:0]  stable_count_next;
  logic [13:0] rpm;
  logic [DIV_W-1:0] rpm_x127;

  assign rise_limit        = {1'b0, item.tach_rpm} < ({1'b0, last_rise} + {1'b0, STEP_RPM})
                             ? 17'd1 : 17'd0;
  assign stable            = rise_limit[0];
  assign stable_count_next = stable ? stable_count + 3'd1 : stable_count;
  assign rpm               = item.target_word[15:2];
  assign rpm_x127          = {rpm, 7'b0} - {7'b0, rpm};

  // round-down results after a division by the step
  logic [15:0] top_round;
  logic        enable_targets;

  assign top_round      = top_speed - div_rem;
  assign enable_targets = {1'b0, top_round} > ({1'b0, first_round} + {1'b0, STEP_RPM});

  result_t result_next;
  always_comb begin
    result_next.pwm_write          = pwm_write;
    result_next.pwm_target_reg     = pwm_reg;
    result_next.pwm_value          = pwm_value;
    result_next.max_speed_word     = {top_speed[13:0], 2'b00};
    result_next.initial_speed_word = {first_round[13:0], 2'b00};
    result_next.min_speed_word     = accept_targets ? 16'd0 : {first_round[13:0], 2'b00};
    result_next.targets_enabled    = accept_targets;
    result_next.busy_calibrating   = calibrating;
    result_next.calibration_done   = done;
  end

  assign item_ready = (state == IDLE);
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= IDLE;
      job            <= JOB_INIT;
      saved_pwm      <= 8'd0;
      first_round    <= 16'd0;
      last_rise      <= 16'd0;
      top_speed      <= 16'd0;
      stable_count   <= 3'd0;
      calibrating    <= 1'b0;
      accept_targets <= 1'b0;
      result_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        saved_pwm <= cfg_data;
      end
      // in FINISH the load below decides the flag
      if (result_valid && result_ready && (state != FINISH)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        IDLE: begin
          if (item_valid) begin
            pwm_write <= 1'b0;
            pwm_reg   <= PWM_REG_FORCE;
            pwm_value <= 8'd0;
            done      <= 1'b0;
            div_rem   <= 16'd0;
            div_cnt   <= DIV_CNT_W'(DIV_W - 1);
            state     <= FINISH;
            unique case (item.opcode)
              OP_START: begin
                top_speed      <= item.tach_rpm;
                last_rise      <= item.tach_rpm;
                stable_count   <= 3'd0;
                calibrating    <= 1'b1;
                accept_targets <= 1'b0;
                pwm_write      <= 1'b1;
                pwm_value      <= FULL_PWM;
                div_quo        <= DIV_W'(item.tach_rpm);
                div_dsr        <= STEP_RPM;
                job            <= JOB_INIT;
                state          <= DIVIDE;
              end
              OP_SAMPLE: begin
                if (calibrating) begin
                  top_speed    <= item.tach_rpm;
                  stable_count <= stable_count_next;
                  if (!stable) begin
                    last_rise <= item.tach_rpm;
                  end
                  if (stable_count_next >= STABLE_LIMIT) begin
                    // end of run: restore the setting, round the maximum
                    calibrating <= 1'b0;
                    done        <= 1'b1;
                    pwm_write   <= 1'b1;
                    pwm_value   <= saved_pwm;
                    div_quo     <= DIV_W'(item.tach_rpm);
                    div_dsr     <= STEP_RPM;
                    job         <= JOB_MAX;
                    state       <= DIVIDE;
                  end
                end
              end
              OP_TARGET: begin
                if (accept_targets && !calibrating && ({2'b00, rpm} <= top_speed)) begin
                  pwm_write <= 1'b1;
                  if (top_speed == 16'd0) begin
                    pwm_value <= saved_pwm;
                  end else begin
                    div_quo <= rpm_x127;
                    div_dsr <= top_speed;
                    job     <= JOB_SLOPE;
                    state   <= DIVIDE;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end

        DIVIDE: begin
          div_rem <= div_rem_next;
          div_quo <= div_quo_next;
          div_cnt <= div_cnt - DIV_CNT_W'(1);
          if (div_cnt == '0) begin
            state <= APPLY;
          end
        end

        APPLY: begin
          unique case (job)
            JOB_INIT: begin
              first_round <= top_round;
            end
            JOB_MAX: begin
              top_speed      <= top_round;
              accept_targets <= enable_targets;
            end
            JOB_SLOPE: begin
              if (div_quo[7:0] == 8'd0) begin
                pwm_reg   <= PWM_REG_FORCE;
                pwm_value <= saved_pwm;
              end else begin
                pwm_reg   <= PWM_REG_START;
                pwm_value <= div_quo[7:0];
              end
            end
            default: begin
            end
          endcase
          state <= FINISH;
        end

        FINISH: begin
          if (!result_valid || result_ready) begin
            result       <= result_next;
            result_valid <= 1'b1;
            state        <= IDLE;
          end
        end

        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  // targets are only taken once a run has finished
  a_accept_idle : assert property (@(posedge clk) disable iff (rst)
    accept_targets |-> !calibrating)
    else $error("targets accepted during a calibration run");

  a_stable_range : assert property (@(posedge clk) disable iff (rst)
    calibrating |-> (stable_count < STABLE_LIMIT))
    else $error("stable count reached limit while still calibrating");

  a_rem_bound : assert property (@(posedge clk) disable iff (rst)
    (state == DIVIDE) |-> (div_rem < div_dsr))
    else $error("divider remainder not below divisor");

  a_one_item : assert property (@(posedge clk) disable iff (rst)
    (item_valid && item_ready) |=> !item_ready)
    else $error("second item taken while one is in work");

  a_done_write : assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.calibration_done) |->
      (result.pwm_write && !result.busy_calibrating &&
       (result.pwm_target_reg == PWM_REG_FORCE)))
    else $error("run end without restoring the saved setting");

endmodule
`default_nettype wire

/* verif/fan_map_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fan_map_checker
// Watches the item, result and config channels of the fan calibration block,
// predicts every result from its own copy of the calibration state and the
// saved PWM byte, and compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module fan_map_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  input  logic              item_ready,
  input  fscm_pkg::item_t   item,
  input  logic              result_valid,
  input  logic              result_ready,
  input  fscm_pkg::result_t result,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [7:0]        cfg_data,
  output int                mismatch_count,
  output int                owed_count
);
  import fscm_pkg::*;

  // calibration state as the block should hold it
  logic [7:0]  pwm_restore;
  logic [15:0] first_tach;
  logic [15:0] rise_rpm;
  logic [15:0] peak_rpm;
  logic [2:0]  steady_samples;
  logic        cal_active;
  logic        targets_open;

  result_t owed_fan_results[$];

  function automatic logic [15:0] floor_to_step(input logic [15:0] rpm);
    return (rpm / STEP_RPM) * STEP_RPM;
  endfunction

  function automatic logic [15:0] rpm_to_fpe2(input logic [15:0] rpm);
    return {rpm[13:0], 2'b00};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns fan_map_checker: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // Advance the calibration state by one item and queue the result it owes.
  task automatic apply_fan_item(input item_t it);
    result_t     r;
    logic [15:0] rpm;
    logic [31:0] slope;
    r = '0;
    case (it.opcode)
      OP_START: begin
        first_tach     = it.tach_rpm;
        peak_rpm       = it.tach_rpm;
        rise_rpm       = it.tach_rpm;
        steady_samples = '0;
        cal_active     = 1'b1;
        targets_open   = 1'b0;
        r.pwm_write      = 1'b1;
        r.pwm_target_reg = PWM_REG_FORCE;
        r.pwm_value      = FULL_PWM;
      end
      OP_SAMPLE: begin
        if (cal_active) begin
          peak_rpm = it.tach_rpm;
          if ({1'b0, it.tach_rpm} < {1'b0, rise_rpm} + 17'(STEP_RPM))
            steady_samples = steady_samples + 3'd1;
          else
            rise_rpm = it.tach_rpm;
          if (steady_samples >= STABLE_LIMIT) begin
            cal_active         = 1'b0;
            r.calibration_done = 1'b1;
            r.pwm_write        = 1'b1;
            r.pwm_target_reg   = PWM_REG_FORCE;
            r.pwm_value        = pwm_restore;
            peak_rpm           = floor_to_step(peak_rpm);
            targets_open = {1'b0, peak_rpm} >
                           {1'b0, floor_to_step(first_tach)} + 17'(STEP_RPM);
          end
        end
      end
      OP_TARGET: begin
        rpm = {2'b00, it.target_word[15:2]};
        if (targets_open && !cal_active && rpm <= peak_rpm) begin
          slope = '0;
          if (peak_rpm != '0)
            slope = (32'(rpm) * 32'(FULL_PWM)) / 32'(peak_rpm);
          r.pwm_write = 1'b1;
          if (slope[7:0] == 8'd0) begin
            r.pwm_target_reg = PWM_REG_FORCE;
            r.pwm_value      = pwm_restore;
          end else begin
            r.pwm_target_reg = PWM_REG_START;
            r.pwm_value      = slope[7:0];
          end
        end
      end
      default: ;
    endcase
    r.max_speed_word     = rpm_to_fpe2(peak_rpm);
    r.initial_speed_word = rpm_to_fpe2(floor_to_step(first_tach));
    r.min_speed_word     = targets_open ? 16'd0 : r.initial_speed_word;
    r.targets_enabled    = targets_open;
    r.busy_calibrating   = cal_active;
    owed_fan_results.push_back(r);
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (owed_fan_results.size() == 0) begin
      report_mismatch("result transaction with no item waiting for it");
    end else begin
      want = owed_fan_results.pop_front();
      compare_field("pwm_write", 16'(got.pwm_write), 16'(want.pwm_write));
      compare_field("pwm_target_reg", 16'(got.pwm_target_reg), 16'(want.pwm_target_reg));
      compare_field("pwm_value", 16'(got.pwm_value), 16'(want.pwm_value));
      compare_field("max_speed_word", got.max_speed_word, want.max_speed_word);
      compare_field("initial_speed_word", got.initial_speed_word,
                    want.initial_speed_word);
      compare_field("min_speed_word", got.min_speed_word, want.min_speed_word);
      compare_field("targets_enabled", 16'(got.targets_enabled),
                    16'(want.targets_enabled));
      compare_field("busy_calibrating", 16'(got.busy_calibrating),
                    16'(want.busy_calibrating));
      compare_field("calibration_done", 16'(got.calibration_done),
                    16'(want.calibration_done));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pwm_restore    = '0;
      first_tach     = '0;
      rise_rpm       = '0;
      peak_rpm       = '0;
      steady_samples = '0;
      cal_active     = 1'b0;
      targets_open   = 1'b0;
      mismatch_count = 0;
      owed_fan_results.delete();
    end else begin
      // drain first: a result never belongs to an item taken at the same edge
      if (result_valid && result_ready)
        check_result(result);
      if (cfg_valid && cfg_ready)
        pwm_restore = cfg_data;
      if (item_valid && item_ready)
        apply_fan_item(item);
    end
    owed_count <= owed_fan_results.size();
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives calibration runs, tach samples, target writes and noise into the fan
// calibration block under several sender and receiver idling patterns, with
// saved PWM byte changes between phases; a checker module scores the results.
// ----------------------------------------------------------------------------
module tb;
  import fscm_pkg::*;

  localparam logic [1:0] OP_RESERVED   = 2'd3;
  localparam int         STALL_LIMIT   = 4000;
  localparam int         DRAIN_LIMIT   = 4000;
  localparam int         SETTLE_CYCLES = 30;
  localparam int         PHASE_ITEMS   = 265;

  logic       clk          = 1'b0;
  logic       rst          = 1'b1;
  logic       item_valid   = 1'b0;
  logic       item_ready;
  item_t      item_bus     = '0;
  logic       result_valid;
  logic       result_ready = 1'b0;
  result_t    result_bus;
  logic       cfg_valid    = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data     = '0;

  int mismatch_count;
  int owed_count;
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_request  = 0;
  int items_fed     = 0;

  fan_speed_calibrate_and_map dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_bus),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_bus),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  fan_map_checker fan_check (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item_bus),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result         (result_bus),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .owed_count     (owed_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver: random stalls, plus long hold-offs counted here
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold         = hold_request;
        hold_request = 0;
      end
      if (hold > 0) begin
        hold--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // end the run once nothing has been accepted for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Offer one item; valid stays high afterwards so the next one can follow
  // back to back.
  task automatic offer(input logic [1:0] op, input logic [15:0] tach,
                       input logic [15:0] word, input bit counted);
    int    gap;
    item_t it;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    it.opcode      = op;
    it.tach_rpm    = tach;
    it.target_word = word;
    item_valid <= 1'b1;
    item_bus   <= it;
    do @(posedge clk); while (!item_ready);
    if (counted) items_fed++;
  endtask

  task automatic write_saved_pwm(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and hold until every owed result is out and the block is idle.
  // Step one edge first so the count includes the last accepted item.
  task automatic quiesce();
    item_valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One calibration run with random content, noise and restarts mixed in,
  // followed by a handful of target writes.
  task automatic calibration_session();
    logic [15:0] rise;
    logic [15:0] last_tach;
    logic [15:0] word;
    int          t;
    int          stable;
    int          top_floor;
    int          ceiling;
    int          rpm;
    int          pick;
    bit          sampled;
    rise = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
    last_tach = rise;
    offer(OP_START, rise, 16'($urandom), 1'b1);
    stable = 0;
    while (stable < int'(STABLE_LIMIT)) begin
      sampled = 1'b0;
      t       = 0;
      pick    = $urandom_range(19);
      if (pick == 0) begin
        offer(OP_RESERVED, 16'($urandom), 16'($urandom), 1'b0);
      end else if (pick == 1) begin
        offer(OP_TARGET, 16'($urandom), 16'($urandom), 1'b0);
      end else if (pick == 2 && $urandom_range(3) == 0) begin
        // restart the run from a fresh reading
        rise = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2000));
        last_tach = rise;
        stable    = 0;
        offer(OP_START, rise, 16'($urandom), 1'b1);
      end else if (pick < 9) begin
        t       = int'(rise) + 50 + $urandom_range(600);
        sampled = 1'b1;
      end else begin
        t       = int'(rise) + $urandom_range(49) -
                  (($urandom_range(3) == 0) ? $urandom_range(2000) : 0);
        sampled = 1'b1;
      end
      if (sampled) begin
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        if (t < int'(rise) + 50) stable++;
        else rise = 16'(t);
        last_tach = 16'(t);
        offer(OP_SAMPLE, 16'(t), 16'($urandom), 1'b1);
      end
    end
    top_floor = (int'(last_tach) / 50) * 50;
    ceiling   = (top_floor > 16383) ? 16383 : top_floor;
    repeat ($urandom_range(6)) begin
      pick = $urandom_range(9);
      if (pick < 7) begin
        rpm  = $urandom_range(ceiling, 0);
        word = 16'((rpm << 2) | $urandom_range(3));
      end else if (pick < 8) begin
        rpm = ceiling + 1 + $urandom_range(49);
        if (rpm > 16383) rpm = 16383;
        word = 16'((rpm << 2) | $urandom_range(3));
      end else begin
        word = 16'($urandom);
      end
      offer(OP_TARGET, 16'($urandom), word, 1'b1);
    end
    // sample or reserved opcode while no run is active
    if ($urandom_range(4) == 0)
      offer(($urandom_range(1) == 0) ? OP_SAMPLE : OP_RESERVED,
            16'($urandom), 16'($urandom), 1'b0);
  endtask

  initial begin
    int phase;
    int drain;
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 84, 0, 27};
    stall_set = '{0, 0, 84, 27};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    send_idle_pct = 30;
    stall_pct     = 30;
    write_saved_pwm(8'h5a);
    offer(OP_SAMPLE, 16'hffff, 16'hffff, 1'b0);
    offer(OP_TARGET, 16'h0000, 16'hffff, 1'b0);
    offer(OP_RESERVED, 16'hffff, 16'hffff, 1'b0);
    offer(OP_START, 16'd1000, 16'h0000, 1'b0);
    offer(OP_SAMPLE, 16'd1100, 16'h0000, 1'b0);
    offer(OP_TARGET, 16'h0000, 16'h0100, 1'b0);
    offer(OP_START, 16'd1020, 16'h0000, 1'b0);
    offer(OP_SAMPLE, 16'd1100, 16'h0000, 1'b0);
    offer(OP_SAMPLE, 16'd1200, 16'h0000, 1'b0);
    offer(OP_SAMPLE, 16'd1210, 16'h0000, 1'b0);
    offer(OP_SAMPLE, 16'd1249, 16'h0000, 1'b0);
    offer(OP_SAMPLE, 16'd1200, 16'h0000, 1'b0);
    offer(OP_SAMPLE, 16'd0,    16'h0000, 1'b0);
    offer(OP_SAMPLE, 16'd1240, 16'h0000, 1'b0);
    offer(OP_TARGET, 16'h0000, 16'd4800, 1'b0);
    offer(OP_TARGET, 16'h0000, 16'd4803, 1'b0);
    offer(OP_TARGET, 16'h0000, 16'd4804, 1'b0);
    offer(OP_TARGET, 16'h0000, 16'd0,    1'b0);
    offer(OP_TARGET, 16'h0000, 16'd40,   1'b0);
    offer(OP_START, 16'd0, 16'hffff, 1'b0);
    repeat (6) offer(OP_SAMPLE, 16'hffff, 16'h0000, 1'b0);
    offer(OP_TARGET, 16'h0000, 16'hffff, 1'b0);
    quiesce();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       write_saved_pwm(8'hff);
        1:       write_saved_pwm(8'h00);
        default: write_saved_pwm(8'($urandom));
      endcase
      send_idle_pct = idle_set[phase];
      stall_pct     = stall_set[phase];
      // hold the receiver off so the block backs up into the item channel
      if (phase == 0) hold_request = 400;
      items_fed = 0;
      while (items_fed < PHASE_ITEMS) calibration_session();
      quiesce();
    end

    drain = 0;
    while (owed_count != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && owed_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
